// File: rtl/core/fifo_page_replacement_assert.svh
// Assertion macros for the FIFO page cache checker.
// No dependencies; each macro expects clk and arst_n in scope.
`ifndef FIFO_PAGE_REPLACEMENT_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_ASSERT_SVH

`define FPR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define FPR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/fpr_pkg.sv
// Shared types and constants for the FIFO page cache.
// No dependencies.
package fpr_pkg;

	localparam int CFG_W     = 7;
	localparam int CFG_RESET = 64;
	localparam int COUNT_W   = 32;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

// File: rtl/core/fifo_page_replacement.sv
// FIFO page cache: a search of one slot per cycle through a RAM with a registered read.
// A miss reads every slot in use before its result is valid; a hit stops at the matching slot.
// The input is ready again in the same cycle as the result is issued, so the block takes
// one reference at a time; a held result stalls the next one.
// After reset a clearing pass writes every slot empty before the first reference is taken.
// Depends on fpr_pkg and fpr_ram.
module fifo_page_replacement #(
	parameter int CAPACITY  = 64,
	parameter int PAGE_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic [PAGE_BITS-1:0]                        page_number,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic                                        hit,
	output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] slot,
	output logic                                        replaced_valid,
	output logic [PAGE_BITS-1:0]                        replaced_page,
	output logic [fpr_pkg::COUNT_W-1:0]                 miss_count,
	output logic [fpr_pkg::COUNT_W-1:0]                 request_count,
	input  logic                                        cfg_valid,
	output logic                                        cfg_ready,
	input  logic [fpr_pkg::CFG_W-1:0]                   cfg_data
);

	localparam int IDX_W      = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
	localparam int SIZE_W     = $clog2(CAPACITY + 1);
	localparam int CMP_W      = SIZE_W > fpr_pkg::CFG_W ? SIZE_W : fpr_pkg::CFG_W;
	localparam int RESET_SIZE = CAPACITY < fpr_pkg::CFG_RESET ? CAPACITY : fpr_pkg::CFG_RESET;
	localparam int ENTRY_W    = PAGE_BITS + 1;

	fpr_pkg::state_t state_q;

	logic [SIZE_W-1:0]           size_q;
	logic [IDX_W-1:0]            fp_q;
	logic [IDX_W-1:0]            clr_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        issue_done_q;
	logic                        vld_s1;
	logic [IDX_W-1:0]            addr_s1;
	logic [PAGE_BITS-1:0]        page_q;
	logic                        hit_q;
	logic [IDX_W-1:0]            slot_q;
	logic [ENTRY_W-1:0]          vic_q;
	logic [fpr_pkg::COUNT_W-1:0] miss_q;
	logic [fpr_pkg::COUNT_W-1:0] req_q;
	logic                        out_valid_q;

	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	logic [ENTRY_W-1:0]          ram_wdata;
	logic                        ram_re;
	logic [ENTRY_W-1:0]          ram_rdata;

	logic [IDX_W-1:0]            last_idx;
	logic [IDX_W-1:0]            victim;
	logic                        match;
	logic                        fire;
	logic                        do_fill;
	logic [SIZE_W-1:0]           next_fp;
	logic [CMP_W-1:0]            cfg_ext;
	logic [CMP_W-1:0]            cfg_eff;

	assign last_idx  = IDX_W'(size_q - 1'b1);
	assign victim    = (SIZE_W'(fp_q) < size_q) ? fp_q : '0;
	assign match     = ram_rdata[PAGE_BITS] && (ram_rdata[PAGE_BITS-1:0] == page_q);
	assign fire      = (state_q == fpr_pkg::ST_FINISH) && (!out_valid_q || out_ready);
	assign do_fill   = fire && !hit_q;
	assign next_fp   = SIZE_W'(slot_q) + 1'b1;
	assign cfg_ext   = CMP_W'(cfg_data);

	always_comb begin
		if (cfg_ext == '0) begin
			cfg_eff = CMP_W'(1);
		end else if (cfg_ext > CMP_W'(CAPACITY)) begin
			cfg_eff = CMP_W'(CAPACITY);
		end else begin
			cfg_eff = cfg_ext;
		end
	end

	assign in_ready  = (state_q == fpr_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	assign ram_re    = (state_q == fpr_pkg::ST_SEARCH) && !issue_done_q;
	assign ram_we    = (state_q == fpr_pkg::ST_CLEAR) || do_fill;
	assign ram_waddr = (state_q == fpr_pkg::ST_CLEAR) ? clr_q : slot_q;
	assign ram_wdata = (state_q == fpr_pkg::ST_CLEAR) ? '0 : {1'b1, page_q};

	fpr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fpr_pkg::ST_CLEAR;
			size_q       <= SIZE_W'(RESET_SIZE);
			fp_q         <= '0;
			clr_q        <= '0;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			miss_q       <= '0;
			req_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= SIZE_W'(cfg_eff);
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				fpr_pkg::ST_CLEAR: begin
					if (clr_q == IDX_W'(CAPACITY - 1)) begin
						state_q <= fpr_pkg::ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				fpr_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q      <= fpr_pkg::ST_SEARCH;
						idx_q        <= '0;
						issue_done_q <= 1'b0;
						vld_s1       <= 1'b0;
					end
				end
				fpr_pkg::ST_SEARCH: begin
					if (!issue_done_q) begin
						vld_s1 <= 1'b1;
						if (idx_q == last_idx) begin
							issue_done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1 && (match || (addr_s1 == last_idx))) begin
						state_q <= fpr_pkg::ST_FINISH;
					end
				end
				fpr_pkg::ST_FINISH: begin
					if (fire) begin
						state_q     <= fpr_pkg::ST_IDLE;
						out_valid_q <= 1'b1;
						if (req_q != '1) begin
							req_q <= req_q + 1'b1;
						end
						if (!hit_q) begin
							if (miss_q != '1) begin
								miss_q <= miss_q + 1'b1;
							end
							fp_q <= (next_fp == size_q) ? '0 : IDX_W'(next_fp);
						end
					end
				end
				default: begin
					state_q <= fpr_pkg::ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			page_q <= page_number;
		end
		if (ram_re) begin
			addr_s1 <= idx_q;
		end
		if ((state_q == fpr_pkg::ST_SEARCH) && vld_s1) begin
			if (addr_s1 == victim) begin
				vic_q <= ram_rdata;
			end
			if (match) begin
				hit_q  <= 1'b1;
				slot_q <= addr_s1;
			end else if (addr_s1 == last_idx) begin
				hit_q  <= 1'b0;
				slot_q <= victim;
			end
		end
		if (fire) begin
			hit            <= hit_q;
			slot           <= slot_q;
			replaced_valid <= !hit_q && vic_q[PAGE_BITS];
			replaced_page  <= (!hit_q && vic_q[PAGE_BITS]) ? vic_q[PAGE_BITS-1:0] : '0;
			miss_count     <= (!hit_q && (miss_q != '1)) ? miss_q + 1'b1 : miss_q;
			request_count  <= (req_q != '1) ? req_q + 1'b1 : req_q;
		end
	end

endmodule

// File: rtl/core/fpr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fpr_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/fpr_checker.sv
// Port-level checker for the FIFO page cache, bound to the top level.
// Depends on fpr_pkg and fifo_page_replacement_assert.svh.
`include "fifo_page_replacement_assert.svh"

module fpr_checker #(
	parameter int PAGE_BITS = 16
) (
	input logic                                        clk,
	input logic                                        arst_n,
	input logic                                        in_valid,
	input logic                                        in_ready,
	input logic                                        out_valid,
	input logic                                        out_ready,
	input logic                                        hit,
	input logic                                        replaced_valid,
	input logic [PAGE_BITS-1:0]                        replaced_page,
	input logic [fpr_pkg::COUNT_W-1:0]                 miss_count,
	input logic [fpr_pkg::COUNT_W-1:0]                 request_count
);

	`FPR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before transfer")
	`FPR_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second reference taken early")
	`FPR_ASSERT_IMP(a_hit_no_victim, out_valid && hit, !replaced_valid, "hit reports a victim")
	`FPR_ASSERT_IMP(a_victim_zero, out_valid && !replaced_valid, replaced_page == '0, "stray victim page")
	`FPR_ASSERT_IMP(a_count_order, out_valid, miss_count <= request_count, "more faults than requests")

endmodule

bind fifo_page_replacement fpr_checker #(
	.PAGE_BITS(PAGE_BITS)
) u_fpr_checker (.*);
